// File: hw/rtl/rrd_pkg.sv
// shared types and constants for the receiver reply deframer
package rrd_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h4D;
    localparam logic [7:0] HDR_SECOND  = 8'h78;
    localparam logic [7:0] LONG_LENGTH = 8'h0B;
    localparam logic [7:0] MIN_SHORT_LENGTH = 8'd4;
    localparam logic [1:0] CHAN_ONE    = 2'd1;
    localparam logic [1:0] CHAN_TWO    = 2'd2;

    localparam logic [1:0] KIND_LONG      = 2'd0;
    localparam logic [1:0] KIND_SHORT_PRM = 2'd1;
    localparam logic [1:0] KIND_SHORT_PD  = 2'd2;

    typedef struct packed {
        logic [1:0]  report_kind;
        logic [15:0] word_value;
        logic [15:0] temperature;
        logic [7:0]  filter_code;
        logic [7:0]  attenuation;
        logic [7:0]  input_index;
    } t_rrd_report;

endpackage

// File: hw/rtl/rrd_parser.sv
// frame state machine: header hunt, payload capture and report build
module rrd_parser
    import rrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    output logic        o_report_valid,
    output t_rrd_report o_report
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_GOT_M,
        PH_GOT_X,
        PH_SKIP,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_chan, n_chan;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_word, n_word;
    logic [7:0]  r_filter, n_filter;
    logic [7:0]  r_atten, n_atten;
    logic [7:0]  r_input, n_input;
    logic [15:0] r_short, n_short;

    logic        w_restart_m;
    logic [7:0]  w_count_inc;
    logic        w_is_long;

    assign w_restart_m = (i_byte == HDR_FIRST);
    assign w_count_inc = r_count + 8'd1;
    assign w_is_long   = (r_len == LONG_LENGTH);

    always_comb begin
        n_phase  = r_phase;
        n_chan   = r_chan;
        n_len    = r_len;
        n_count  = r_count;
        n_temp   = r_temp;
        n_word   = r_word;
        n_filter = r_filter;
        n_atten  = r_atten;
        n_input  = r_input;
        n_short  = r_short;
        case (r_phase)
            PH_HUNT: begin
                n_phase = w_restart_m ? PH_GOT_M : PH_HUNT;
            end
            PH_GOT_M: begin
                if (i_byte == HDR_SECOND) begin
                    n_phase = PH_GOT_X;
                end else begin
                    n_phase = w_restart_m ? PH_GOT_M : PH_HUNT;
                end
            end
            PH_GOT_X: begin
                if (i_byte == {6'd0, CHAN_ONE} || i_byte == {6'd0, CHAN_TWO}) begin
                    n_chan   = i_byte[1:0];
                    n_len    = '0;
                    n_count  = '0;
                    n_temp   = '0;
                    n_word   = '0;
                    n_filter = '0;
                    n_atten  = '0;
                    n_input  = '0;
                    n_short  = '0;
                    n_phase  = PH_SKIP;
                end else begin
                    n_phase = w_restart_m ? PH_GOT_M : PH_HUNT;
                end
            end
            PH_SKIP: begin
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_len   = i_byte;
                n_count = '0;
                n_phase = (i_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                // payload position selects which capture field takes the byte
                case (r_count)
                    8'd2:    n_short[15:8] = i_byte;
                    8'd3:    n_short[7:0]  = i_byte;
                    8'd4:    n_temp[15:8]  = i_byte;
                    8'd5:    n_temp[7:0]   = i_byte;
                    8'd6:    n_word[15:8]  = i_byte;
                    8'd7:    n_word[7:0]   = i_byte;
                    8'd8:    n_filter      = i_byte;
                    8'd9:    n_atten       = i_byte;
                    8'd10:   n_input       = i_byte;
                    default: ;
                endcase
                n_count = w_count_inc;
                if (w_count_inc == r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_chan   <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_temp   <= '0;
            r_word   <= '0;
            r_filter <= '0;
            r_atten  <= '0;
            r_input  <= '0;
            r_short  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_chan   <= n_chan;
            r_len    <= n_len;
            r_count  <= n_count;
            r_temp   <= n_temp;
            r_word   <= n_word;
            r_filter <= n_filter;
            r_atten  <= n_atten;
            r_input  <= n_input;
            r_short  <= n_short;
        end
    end

    // report is set by the check byte, its value does not matter
    always_comb begin
        o_report_valid = 1'b0;
        o_report       = '0;
        if (r_phase == PH_CHECK) begin
            if (w_is_long) begin
                o_report_valid       = (r_chan == CHAN_TWO);
                o_report.report_kind = KIND_LONG;
                o_report.word_value  = r_word;
                o_report.temperature = r_temp;
                o_report.filter_code = r_filter;
                o_report.attenuation = r_atten;
                o_report.input_index = r_input;
            end else begin
                o_report_valid       = (r_len >= MIN_SHORT_LENGTH);
                o_report.report_kind = (r_chan == CHAN_TWO) ? KIND_SHORT_PRM
                                                            : KIND_SHORT_PD;
                o_report.word_value  = r_short;
            end
        end
    end

`ifndef ASSERT_OFF
    a_check_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_CHECK) |=> (r_phase == PH_HUNT))
        else $error("check byte did not end the frame");
    a_count_within_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_count < r_len))
        else $error("payload count ran past frame length");
    a_long_is_prm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_report_valid && o_report.report_kind == KIND_LONG) |-> (r_chan == CHAN_TWO))
        else $error("long report on wrong channel");
`endif

endmodule

// File: hw/rtl/rrd_out_stage.sv
// result register between the parser and the report channel
module rrd_out_stage
    import rrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_rrd_report i_report,
    input  logic        i_ready,
    output logic        o_free,
    output logic        o_valid,
    output t_rrd_report o_report
);

    logic        r_valid;
    t_rrd_report r_report;

    // slot is free when empty or being taken this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_report <= i_report;
        end
    end

    assign o_valid  = r_valid;
    assign o_report = r_report;

endmodule

// File: hw/rtl/receiver_reply_deframer.sv
// top level of the receiver reply deframer
// Takes one received byte per transfer and reports at most one result per completed
// frame ('M','x',channel 1 or 2, a skipped byte, length, payload, check byte).
// A byte can be taken every cycle: it is held in an input register, from which
// the frame state machine takes it; the report, sent on the check byte, lands
// in a result register when that byte moves on. The input stalls only when a
// report must be loaded while the previous one is still waiting to be taken.
module receiver_reply_deframer
    import rrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_rep_valid,
    input  logic        i_rep_ready,
    output logic [1:0]  o_report_kind,
    output logic [15:0] o_word_value,
    output logic [15:0] o_temperature,
    output logic [7:0]  o_filter_code,
    output logic [7:0]  o_attenuation,
    output logic [7:0]  o_input_index
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        w_advance;
    logic        w_out_free;
    logic        w_rep_valid;
    t_rrd_report w_report;
    t_rrd_report w_out_report;

    // held byte moves on unless its report has nowhere to go
    assign w_advance  = r_in_valid && (!w_rep_valid || w_out_free);
    assign o_rx_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rrd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_advance),
        .i_byte         (r_in_byte),
        .o_report_valid (w_rep_valid),
        .o_report       (w_report)
    );

    rrd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_rep_valid),
        .i_report (w_report),
        .i_ready  (i_rep_ready),
        .o_free   (w_out_free),
        .o_valid  (o_rep_valid),
        .o_report (w_out_report)
    );

    assign o_report_kind = w_out_report.report_kind;
    assign o_word_value  = w_out_report.word_value;
    assign o_temperature = w_out_report.temperature;
    assign o_filter_code = w_out_report.filter_code;
    assign o_attenuation = w_out_report.attenuation;
    assign o_input_index = w_out_report.input_index;

`ifndef ASSERT_OFF
    a_held_byte_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost while stalled");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rep_valid && !i_rep_ready) |-> !(w_advance && w_rep_valid))
        else $error("pending report overwritten");
    a_stall_only_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (w_rep_valid && o_rep_valid && !i_rep_ready))
        else $error("input stalled without a blocked report");
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rep_valid |-> (o_report_kind == KIND_LONG || o_report_kind == KIND_SHORT_PRM
                         || o_report_kind == KIND_SHORT_PD))
        else $error("report kind out of range");
`endif

endmodule

// File: sim/tb_receiver_reply_deframer.sv
// testbench for the receiver reply deframer: byte stream in, reports checked by a predictor
`timescale 1ns / 100ps

module tb_receiver_reply_deframer;
    import rrd_pkg::*;

    typedef enum logic [2:0] {
        SCAN_HUNT, SCAN_GOT_M, SCAN_GOT_X, SCAN_SKIP, SCAN_LENGTH, SCAN_PAYLOAD, SCAN_CHECK
    } t_scan_phase;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;
    localparam int FILL_RAMP   = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_rep_valid;
    logic        i_rep_ready;
    logic [1:0]  o_report_kind;
    logic [15:0] o_word_value;
    logic [15:0] o_temperature;
    logic [7:0]  o_filter_code;
    logic [7:0]  o_attenuation;
    logic [7:0]  o_input_index;

    // frame tracker state
    t_scan_phase scan_phase    = SCAN_HUNT;
    logic [1:0]  frame_channel = '0;
    logic [7:0]  frame_length  = '0;
    logic [7:0]  frame_count   = '0;
    logic [15:0] cap_temp      = '0;
    logic [15:0] cap_freq      = '0;
    logic [7:0]  cap_filter    = '0;
    logic [7:0]  cap_atten     = '0;
    logic [7:0]  cap_input     = '0;
    logic [15:0] cap_short     = '0;

    t_rrd_report expected_reports[$];
    logic [7:0]  payload_buf[$];
    int          error_count   = 0;
    int          rx_gap_max    = 16;
    int          rep_stall_max = 16;
    int          hold_off_len  = 0;

    receiver_reply_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_rep_valid   (o_rep_valid),
        .i_rep_ready   (i_rep_ready),
        .o_report_kind (o_report_kind),
        .o_word_value  (o_word_value),
        .o_temperature (o_temperature),
        .o_filter_code (o_filter_code),
        .o_attenuation (o_attenuation),
        .o_input_index (o_input_index)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_scan_phase hunt_restart(input logic [7:0] b);
        return (b == HDR_FIRST) ? SCAN_GOT_M : SCAN_HUNT;
    endfunction

    // advance the frame tracker by one byte, queue the report a finished frame gives
    function automatic void track_rx_byte(input logic [7:0] b);
        t_rrd_report rep;
        rep = '0;
        case (scan_phase)
            SCAN_HUNT: scan_phase = hunt_restart(b);
            SCAN_GOT_M: begin
                if (b == HDR_SECOND) scan_phase = SCAN_GOT_X;
                else scan_phase = hunt_restart(b);
            end
            SCAN_GOT_X: begin
                if (b == {6'd0, CHAN_ONE} || b == {6'd0, CHAN_TWO}) begin
                    frame_channel = b[1:0];
                    frame_length  = '0;
                    frame_count   = '0;
                    cap_temp      = '0;
                    cap_freq      = '0;
                    cap_filter    = '0;
                    cap_atten     = '0;
                    cap_input     = '0;
                    cap_short     = '0;
                    scan_phase    = SCAN_SKIP;
                end else begin
                    scan_phase = hunt_restart(b);
                end
            end
            SCAN_SKIP: scan_phase = SCAN_LENGTH;
            SCAN_LENGTH: begin
                frame_length = b;
                frame_count  = '0;
                scan_phase   = (b == 8'd0) ? SCAN_CHECK : SCAN_PAYLOAD;
            end
            SCAN_PAYLOAD: begin
                case (frame_count)
                    8'd2:  cap_short[15:8] = b;
                    8'd3:  cap_short[7:0]  = b;
                    8'd4:  cap_temp[15:8]  = b;
                    8'd5:  cap_temp[7:0]   = b;
                    8'd6:  cap_freq[15:8]  = b;
                    8'd7:  cap_freq[7:0]   = b;
                    8'd8:  cap_filter      = b;
                    8'd9:  cap_atten       = b;
                    8'd10: cap_input       = b;
                    default: ;
                endcase
                frame_count = frame_count + 8'd1;
                if (frame_count == frame_length) scan_phase = SCAN_CHECK;
            end
            default: begin
                // check byte closes the frame, its value is ignored
                scan_phase = SCAN_HUNT;
                if (frame_length == LONG_LENGTH) begin
                    if (frame_channel == CHAN_TWO) begin
                        rep.report_kind = KIND_LONG;
                        rep.word_value  = cap_freq;
                        rep.temperature = cap_temp;
                        rep.filter_code = cap_filter;
                        rep.attenuation = cap_atten;
                        rep.input_index = cap_input;
                        expected_reports.push_back(rep);
                    end
                end else if (frame_length >= MIN_SHORT_LENGTH) begin
                    rep.report_kind = (frame_channel == CHAN_TWO) ? KIND_SHORT_PRM
                                                                  : KIND_SHORT_PD;
                    rep.word_value  = cap_short;
                    expected_reports.push_back(rep);
                end
            end
        endcase
    endfunction

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10)
                $display("report mismatch on %s: expected %h, got %h", fname, want, got);
        end
    endtask

    task automatic check_report();
        t_rrd_report want;
        if (expected_reports.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected report: kind %0d word %h temp %h", o_report_kind,
                         o_word_value, o_temperature);
        end else begin
            want = expected_reports.pop_front();
            compare_field("report_kind", 16'(want.report_kind), 16'(o_report_kind));
            compare_field("word_value", want.word_value, o_word_value);
            compare_field("temperature", want.temperature, o_temperature);
            compare_field("filter_code", 16'(want.filter_code), 16'(o_filter_code));
            compare_field("attenuation", 16'(want.attenuation), 16'(o_attenuation));
            compare_field("input_index", 16'(want.input_index), 16'(o_input_index));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_rep_valid && i_rep_ready) check_report();
    end

    // report side: random stall per transfer, plus a long hold-off on request
    initial begin
        int stall;
        i_rep_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = (rep_stall_max == 0) ? 0 : $urandom_range(rep_stall_max, 0);
            if (hold_off_len != 0) begin
                stall = hold_off_len;
                hold_off_len = 0;
            end
            if (stall != 0) begin
                i_rep_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_rep_ready <= 1'b1;
            do @(posedge i_clk);
            while (!(o_rep_valid && i_rep_ready) && hold_off_len == 0);
            @(negedge i_clk);
        end
    end

    // called and returns at a falling edge, leaves valid high for the next byte
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
        if (gap != 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!(i_rx_valid && o_rx_ready));
        track_rx_byte(b);
        @(negedge i_clk);
    endtask

    task automatic wait_reports_drained();
        i_rx_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic void fill_payload(input int len, input int style);
        payload_buf.delete();
        for (int i = 0; i < len; i++) begin
            case (style)
                FILL_ONES:  payload_buf.push_back(8'hFF);
                FILL_ZEROS: payload_buf.push_back(8'h00);
                FILL_RAMP:  payload_buf.push_back(8'(i * 8'h11 + 1));
                default: begin
                    // sprinkle header-like bytes into the payload
                    case ($urandom_range(15, 0))
                        0: payload_buf.push_back(HDR_FIRST);
                        1: payload_buf.push_back(HDR_SECOND);
                        2: payload_buf.push_back({6'd0, CHAN_TWO});
                        default: payload_buf.push_back(8'($urandom));
                    endcase
                end
            endcase
        end
    endfunction

    task automatic send_frame(input logic [7:0] chan, input logic [7:0] check);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(chan);
        send_byte(($urandom_range(4, 0) == 0) ? HDR_FIRST : 8'($urandom));
        send_byte(8'(payload_buf.size()));
        foreach (payload_buf[i]) send_byte(payload_buf[i]);
        send_byte(check);
    endtask

    task automatic test_directed_frames();
        logic [7:0] prm;
        logic [7:0] pd;
        prm = {6'd0, CHAN_TWO};
        pd  = {6'd0, CHAN_ONE};
        send_byte(8'h00);
        send_byte(8'hFF);
        fill_payload(int'(LONG_LENGTH), FILL_ONES);
        send_frame(prm, 8'h00);
        fill_payload(int'(LONG_LENGTH), FILL_RAMP);
        send_frame(prm, 8'hA5);
        fill_payload(int'(LONG_LENGTH), FILL_ZEROS);
        send_frame(prm, 8'hFF);
        fill_payload(4, FILL_RAMP);
        send_frame(pd, 8'h3C);
        fill_payload(4, FILL_ONES);
        send_frame(prm, 8'h00);
        fill_payload(255, FILL_RANDOM);
        send_frame(prm, 8'h5A);
        // empty payload, then too short for a value, then long on channel 1
        fill_payload(0, FILL_RANDOM);
        send_frame(prm, 8'h11);
        fill_payload(3, FILL_ONES);
        send_frame(pd, 8'h22);
        fill_payload(int'(LONG_LENGTH), FILL_RAMP);
        send_frame(pd, 8'h33);
        // broken header: a repeated 'M' starts a new hunt
        send_byte(HDR_FIRST);
        fill_payload(5, FILL_RAMP);
        send_frame(prm, 8'h44);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        fill_payload(6, FILL_ZEROS);
        send_frame(pd, 8'h55);
        // unknown channel bytes
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'h00);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'h03);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'hFF);
        // header bytes inside the payload are plain data
        payload_buf.delete();
        payload_buf.push_back(HDR_FIRST);
        payload_buf.push_back(HDR_SECOND);
        payload_buf.push_back(prm);
        payload_buf.push_back(8'h12);
        payload_buf.push_back(8'h34);
        send_frame(pd, HDR_FIRST);
        wait_reports_drained();
    endtask

    task automatic test_receiver_hold_off();
        rx_gap_max   = 0;
        hold_off_len = 400;
        for (int n = 0; n < 8; n++) begin
            fill_payload($urandom_range(6, 4), FILL_RANDOM);
            send_frame((n % 2 == 0) ? {6'd0, CHAN_TWO} : {6'd0, CHAN_ONE}, 8'($urandom));
        end
        wait_reports_drained();
        rx_gap_max = 16;
    endtask

    task automatic test_random_stream();
        int frame_bytes;
        int pick;
        int len;
        frame_bytes = 0;
        while (frame_bytes < 160) begin
            rx_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : 16;
            rep_stall_max = ($urandom_range(3, 0) == 0) ? 0 : 16;
            pick = $urandom_range(99, 0);
            if (pick < 80) begin
                pick = $urandom_range(99, 0);
                if (pick < 10)      len = $urandom_range(3, 0);
                else if (pick < 45) len = $urandom_range(10, 4);
                else if (pick < 80) len = int'(LONG_LENGTH);
                else if (pick < 98) len = $urandom_range(40, 12);
                else                len = $urandom_range(255, 41);
                fill_payload(len, FILL_RANDOM);
                send_frame($urandom_range(1, 0) ? {6'd0, CHAN_TWO} : {6'd0, CHAN_ONE},
                           8'($urandom));
                frame_bytes += len + 6;
            end else begin
                case ($urandom_range(3, 0))
                    0: repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
                    1: begin
                        send_byte(HDR_FIRST);
                        send_byte($urandom_range(1, 0) ? HDR_FIRST : 8'($urandom));
                    end
                    2: begin
                        send_byte(HDR_FIRST);
                        send_byte(HDR_SECOND);
                        send_byte($urandom_range(1, 0) ? 8'h00 : 8'($urandom_range(255, 3)));
                    end
                    default: begin
                        send_byte(HDR_FIRST);
                        send_byte(HDR_SECOND);
                        send_byte(HDR_FIRST);
                    end
                endcase
            end
            if ($urandom_range(19, 0) == 0) wait_reports_drained();
        end
        rx_gap_max    = 16;
        rep_stall_max = 16;
        wait_reports_drained();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte  = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_frames();
        test_receiver_hold_off();
        test_random_stream();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("receiver_reply_deframer verification clean");
        end else begin
            $display("receiver_reply_deframer verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("receiver_reply_deframer verification failed");
        $finish;
    end

endmodule
